// ===== design/assert_macros.svh =====
// assertion macros used by the checker file mcs_checker
// expects clk and rst to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication into the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mcs_pkg.sv =====
// types, codes and the cqi table of the max-cqi frame scheduler
// no dependencies
package mcs_pkg;

  localparam logic [1:0] REG_USER_COUNT  = 2'd0;
  localparam logic [1:0] REG_QUEUE_LIMIT = 2'd1;
  localparam logic [1:0] REG_FRAME_RBS   = 2'd2;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_REPORT  = 1'b1;

  localparam logic [1:0] KIND_QUEUED  = 2'd0;
  localparam logic [1:0] KIND_DROPPED = 2'd1;
  localparam logic [1:0] KIND_SERVED  = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  typedef struct packed {
    logic [2:0] user_count;
    logic [4:0] queue_limit;
    logic [6:0] frame_rbs;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  user_id;
    logic [11:0] pkt_bytes;
    logic [31:0] arrival_stamp;
    logic [3:0]  cqi_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  user;
    logic [11:0] size;
    logic [31:0] stamp;
    logic [13:0] bytes;
    logic        last;
  } result_t;

  function automatic logic [6:0] bytes_per_rb(input logic [3:0] cqi);
    logic [6:0] b;
    case (cqi)
      4'd0:    b = 7'd0;
      4'd1:    b = 7'd3;
      4'd2:    b = 7'd3;
      4'd3:    b = 7'd6;
      4'd4:    b = 7'd11;
      4'd5:    b = 7'd15;
      4'd6:    b = 7'd20;
      4'd7:    b = 7'd25;
      4'd8:    b = 7'd36;
      4'd9:    b = 7'd39;
      4'd10:   b = 7'd50;
      4'd11:   b = 7'd63;
      4'd12:   b = 7'd72;
      4'd13:   b = 7'd80;
      default: b = 7'd93;
    endcase
    return b;
  endfunction

endpackage

// ===== design/max_cqi_frame_scheduler.sv =====
// max-cqi frame scheduler top level: config registers, front queue, back end
// depends on mcs_pkg, mcs_front, mcs_back
// arrival: queued in the front queue, then the output register; one item per
// cycle while results are popped and no frame is built; report: the memory read
// loop serves packets per user, takes the rbs used, then closes the frame
// reset: synchronous, queues empty, no reports, registers at 4 / 16 / 25
module max_cqi_frame_scheduler #(
  parameter int MAX_USERS   = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [1:0]  user_id,
  input  logic [11:0] pkt_bytes,
  input  logic [31:0] arrival_stamp,
  input  logic [3:0]  cqi_value,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [1:0]  served_user,
  output logic [11:0] served_size,
  output logic [31:0] served_stamp,
  output logic [13:0] frame_bytes,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  mcs_pkg::cfg_t    cfg;
  mcs_pkg::cmd_t    in_cmd;
  mcs_pkg::cmd_t    cmd;
  mcs_pkg::result_t res;
  logic             cmd_valid;
  logic             cmd_pop;
  logic             res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.user_count  <= 3'd4;
      cfg.queue_limit <= 5'd16;
      cfg.frame_rbs   <= 7'd25;
    end else if (cfg_we) begin
      case (cfg_index)
        mcs_pkg::REG_USER_COUNT:  cfg.user_count  <= cfg_data[2:0];
        mcs_pkg::REG_QUEUE_LIMIT: cfg.queue_limit <= cfg_data[4:0];
        mcs_pkg::REG_FRAME_RBS:   cfg.frame_rbs   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_cmd = '{req_type, user_id, pkt_bytes, arrival_stamp, cqi_value};

  mcs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_cmd   (in_cmd),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  mcs_back #(
    .MAX_USERS  (MAX_USERS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res      (res),
    .res_valid(res_valid),
    .res_pop  (pop)
  );

  assign empty        = !res_valid;
  assign result_kind  = res.kind;
  assign served_user  = res.user;
  assign served_size  = res.size;
  assign served_stamp = res.stamp;
  assign frame_bytes  = res.bytes;
  assign last         = res.last;

endmodule

// ===== design/mcs_front.sv =====
// front end: takes input transfers into a two-entry command queue
// depends on mcs_pkg
module mcs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  mcs_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  output mcs_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  mcs_pkg::cmd_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !cmd_pop) begin
        count <= count + 2'd1;
      end else if (!do_push && cmd_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== design/mcs_back.sv =====
// back end: per-user packet queues, cqi records and the frame builder
// depends on mcs_pkg
module mcs_back #(
  parameter int MAX_USERS   = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  mcs_pkg::cfg_t    cfg,
  input  logic             cmd_valid,
  input  mcs_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output mcs_pkg::result_t res,
  output logic             res_valid,
  input  logic             res_pop
);

  localparam int UW    = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW    = PW + 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = MAX_USERS * QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SELECT    = 3'd1;
  localparam logic [2:0] S_HEAD_RD   = 3'd2;
  localparam logic [2:0] S_HEAD_WAIT = 3'd3;
  localparam logic [2:0] S_ROUND     = 3'd4;

  logic [43:0]          mem [DEPTH];
  logic [43:0]          rdata;
  logic [PW-1:0]        head [MAX_USERS];
  logic [CW-1:0]        cnt  [MAX_USERS];
  logic [3:0]           cqi  [MAX_USERS];
  logic [MAX_USERS-1:0] mask;
  logic [MAX_USERS-1:0] done;
  logic [2:0]           state;
  logic [UW-1:0]        best;
  logic [6:0]           dim;
  logic [13:0]          budget;
  logic [13:0]          used;
  logic [13:0]          acc;
  logic [13:0]          total;
  logic [6:0]           rem;
  mcs_pkg::result_t     pend;
  logic                 pvalid;
  mcs_pkg::result_t     out;
  logic                 ovalid;

  logic [3:0]           nusers;
  logic                 uid_ok;
  logic [UW-1:0]        ui;
  logic [6:0]           lim;
  logic                 can_queue;
  logic [SW-1:0]        ssum;
  logic [PW-1:0]        slot;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [MAX_USERS-1:0] new_mask;
  logic                 all_rep;
  logic                 found;
  logic [UW-1:0]        pick;
  logic [6:0]           dim_sel;
  logic [11:0]          sz;
  logic                 fits;
  logic                 out_free;
  logic                 out_load;
  logic                 mem_we;
  logic                 mem_re;
  logic [PW-1:0]        head_inc;

  assign res       = out;
  assign res_valid = ovalid;
  assign out_free  = !ovalid || res_pop;

  always_comb begin
    if (cfg.user_count == 3'd0) begin
      nusers = 4'd1;
    end else if ({1'b0, cfg.user_count} > 4'(MAX_USERS)) begin
      nusers = 4'(MAX_USERS);
    end else begin
      nusers = {1'b0, cfg.user_count};
    end
    if (7'(cfg.queue_limit) > 7'(QUEUE_DEPTH)) begin
      lim = 7'(QUEUE_DEPTH);
    end else begin
      lim = 7'(cfg.queue_limit);
    end
  end

  assign uid_ok    = {2'b00, cmd.user_id} < nusers;
  assign ui        = UW'(cmd.user_id);
  assign can_queue = uid_ok && (7'(cnt[ui]) < lim);
  assign ssum      = SW'(head[ui]) + SW'(cnt[ui]);
  assign slot      = (ssum >= SW'(QUEUE_DEPTH)) ? PW'(ssum - SW'(QUEUE_DEPTH)) : PW'(ssum);
  assign waddr     = AW'(ui) * AW'(QUEUE_DEPTH) + AW'(slot);
  assign raddr     = AW'(best) * AW'(QUEUE_DEPTH) + AW'(head[best]);
  assign head_inc  = (SW'(head[best]) + SW'(1) == SW'(QUEUE_DEPTH)) ? '0 : head[best] + PW'(1);

  always_comb begin
    all_rep = 1'b1;
    for (int u = 0; u < MAX_USERS; u++) begin
      new_mask[u] = mask[u] || (uid_ok && (UW'(u) == ui));
      if ((4'(u) < nusers) && !new_mask[u]) begin
        all_rep = 1'b0;
      end
    end
  end

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int u = 0; u < MAX_USERS; u++) begin
      if ((4'(u) < nusers) && !done[u] && (!found || (cqi[u] > cqi[pick]))) begin
        pick  = UW'(u);
        found = 1'b1;
      end
    end
  end

  assign dim_sel = mcs_pkg::bytes_per_rb(cqi[pick]);
  assign sz      = rdata[43:32];
  assign fits    = {2'b00, sz} <= (budget - used);

  assign cmd_pop = (state == S_IDLE) && cmd_valid &&
                   ((cmd.req_type == mcs_pkg::REQ_REPORT) || out_free);
  assign mem_we  = cmd_pop && (cmd.req_type == mcs_pkg::REQ_ARRIVAL) && can_queue;
  assign mem_re  = (state == S_HEAD_RD) && (cnt[best] != '0);

  assign out_load = (cmd_pop && (cmd.req_type == mcs_pkg::REQ_ARRIVAL)) ||
                    ((state == S_SELECT) && !found && out_free) ||
                    ((state == S_HEAD_WAIT) && fits && pvalid && out_free);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= {cmd.pkt_bytes, cmd.arrival_stamp};
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mask   <= '0;
      done   <= '0;
      ovalid <= 1'b0;
      pvalid <= 1'b0;
      for (int u = 0; u < MAX_USERS; u++) begin
        head[u] <= '0;
        cnt[u]  <= '0;
        cqi[u]  <= '0;
      end
    end else begin
      if (out_load) begin
        ovalid <= 1'b1;
      end else if (res_pop) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            if (cmd.req_type == mcs_pkg::REQ_ARRIVAL) begin
              out.kind  <= can_queue ? mcs_pkg::KIND_QUEUED : mcs_pkg::KIND_DROPPED;
              out.user  <= cmd.user_id;
              out.size  <= cmd.pkt_bytes;
              out.stamp <= cmd.arrival_stamp;
              out.bytes <= '0;
              out.last  <= 1'b1;
              if (can_queue) begin
                cnt[ui] <= cnt[ui] + CW'(1);
              end
            end else if (uid_ok) begin
              cqi[ui] <= cmd.cqi_value;
              if (all_rep) begin
                mask   <= '0;
                done   <= '0;
                rem    <= cfg.frame_rbs;
                total  <= '0;
                pvalid <= 1'b0;
                state  <= S_SELECT;
              end else begin
                mask <= new_mask;
              end
            end
          end
        end
        S_SELECT: begin
          if (found) begin
            done[pick] <= 1'b1;
            best       <= pick;
            dim        <= dim_sel;
            budget     <= 14'(rem) * 14'(dim_sel);
            used       <= '0;
            acc        <= '0;
            state      <= (dim_sel == 7'd0) ? S_SELECT : S_HEAD_RD;
          end else if (out_free) begin
            if (pvalid) begin
              out <= {pend.kind, pend.user, pend.size, pend.stamp, total, 1'b1};
            end else begin
              out.kind  <= mcs_pkg::KIND_EMPTY;
              out.user  <= '0;
              out.size  <= '0;
              out.stamp <= '0;
              out.bytes <= '0;
              out.last  <= 1'b1;
            end
            pvalid <= 1'b0;
            state  <= S_IDLE;
          end
        end
        S_HEAD_RD: begin
          state <= (cnt[best] == '0) ? S_ROUND : S_HEAD_WAIT;
        end
        S_HEAD_WAIT: begin
          if (!fits) begin
            state <= S_ROUND;
          end else if (!pvalid || out_free) begin
            if (pvalid) begin
              out <= pend;
            end
            pend.kind  <= mcs_pkg::KIND_SERVED;
            pend.user  <= 2'(best);
            pend.size  <= sz;
            pend.stamp <= rdata[31:0];
            pend.bytes <= '0;
            pend.last  <= 1'b0;
            pvalid     <= 1'b1;
            used       <= used + 14'(sz);
            total      <= total + 14'(sz);
            head[best] <= head_inc;
            cnt[best]  <= cnt[best] - CW'(1);
            state      <= S_HEAD_RD;
          end
        end
        S_ROUND: begin
          // take whole rbs until the bytes used are covered
          if (acc < used) begin
            acc <= acc + 14'(dim);
            rem <= rem - 7'd1;
          end else begin
            state <= S_SELECT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/mcs_checker.sv =====
// port-level checks on the scheduler result stream, bound to the top level
// depends on mcs_pkg and assert_macros.svh
`include "assert_macros.svh"

module mcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  result_kind,
  input logic [11:0] served_size,
  input logic [31:0] served_stamp,
  input logic [13:0] frame_bytes,
  input logic        last
);

  `ASSERT_IMPL(a_empty_frame, !empty && (result_kind == mcs_pkg::KIND_EMPTY), last && (served_size == 12'd0) && (served_stamp == 32'd0) && (frame_bytes == 14'd0), "empty frame result not clean")
  `ASSERT_IMPL(a_arrival_last, !empty && ((result_kind == mcs_pkg::KIND_QUEUED) || (result_kind == mcs_pkg::KIND_DROPPED)), last && (frame_bytes == 14'd0), "arrival result malformed")
  `ASSERT_IMPL(a_mid_frame, !empty && (result_kind == mcs_pkg::KIND_SERVED) && !last, frame_bytes == 14'd0, "byte total before end of frame")
  `ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result_kind) && $stable(served_stamp), "stalled result changed")

endmodule

bind max_cqi_frame_scheduler mcs_checker u_chk (.*);

// ===== verif/max_cqi_frame_scheduler_tb.sv =====
// self-checking testbench for the max-cqi frame scheduler: arrivals, cqi reports, frame build
// depends on mcs_pkg and max_cqi_frame_scheduler; predicts every result and checks in order
`timescale 1ns / 1ps
module max_cqi_frame_scheduler_tb;

  localparam int NUSR = 4;
  localparam int QDEP = 16;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        req_type = mcs_pkg::REQ_ARRIVAL;
  logic [1:0]  user_id = '0;
  logic [11:0] pkt_bytes = '0;
  logic [31:0] arrival_stamp = '0;
  logic [3:0]  cqi_value = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  result_kind;
  logic [1:0]  served_user;
  logic [11:0] served_size;
  logic [31:0] served_stamp;
  logic [13:0] frame_bytes;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = mcs_pkg::REG_USER_COUNT;
  logic [6:0]  cfg_data = '0;

  max_cqi_frame_scheduler DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler model state
  mcs_pkg::cfg_t cfg_m;
  logic [43:0]   pkt_mem [NUSR*QDEP];
  int unsigned   q_head [NUSR];
  int unsigned   q_cnt [NUSR];
  logic [3:0]    cqi_m [NUSR];
  bit            rep_seen [NUSR];

  mcs_pkg::cmd_t    pending_cmds [$];
  mcs_pkg::result_t expected_results [$];
  int      errors = 0;
  int      n_items = 0, n_results = 0, n_frames = 0, n_drops = 0;
  bit      hold_push = 1'b0;

  function automatic int unsigned active_users();
    int unsigned u = cfg_m.user_count;
    if (u == 0) u = 1;
    if (u > NUSR) u = NUSR;
    return u;
  endfunction

  function automatic mcs_pkg::result_t mk(logic [1:0] k, logic [1:0] u, logic [11:0] s,
                                          logic [31:0] st, logic [13:0] b, logic l);
    mcs_pkg::result_t r;
    r.kind = k; r.user = u; r.size = s; r.stamp = st; r.bytes = b; r.last = l;
    return r;
  endfunction

  function automatic int unsigned rb_bytes(logic [3:0] c);
    int unsigned t [16] = '{0, 3, 3, 6, 11, 15, 20, 25, 36, 39, 50, 63, 72, 80, 93, 93};
    return t[c];
  endfunction

  task automatic expect_result(mcs_pkg::result_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic build_frame_results(int unsigned nu);
    bit               done [NUSR];
    int unsigned      rem_rb, total, used, dim, budget, best, h, sz, first_idx;
    bit               found;
    mcs_pkg::result_t tail;
    rem_rb = cfg_m.frame_rbs;
    total = 0;
    first_idx = expected_results.size();
    for (int i = 0; i < NUSR; i++) done[i] = 1'b0;
    for (int v = 0; v < nu; v++) begin
      found = 1'b0; best = 0;
      for (int u = 0; u < nu; u++)
        if (!done[u] && (!found || cqi_m[u] > cqi_m[best])) begin
          best = u; found = 1'b1;
        end
      done[best] = 1'b1;
      dim = rb_bytes(cqi_m[best]);
      if (dim == 0) continue;
      budget = rem_rb * dim;
      used = 0;
      while (q_cnt[best] > 0) begin
        h = q_head[best];
        sz = pkt_mem[best*QDEP + h][43:32];
        if (sz > budget - used) break;
        used += sz; total += sz;
        expect_result(mk(mcs_pkg::KIND_SERVED, best[1:0], sz[11:0],
                         pkt_mem[best*QDEP + h][31:0], '0, 1'b0));
        q_head[best] = (h + 1) % QDEP;
        q_cnt[best]--;
      end
      rem_rb -= used / dim + ((used % dim) ? 1 : 0);
    end
    if (expected_results.size() == first_idx)
      expect_result(mk(mcs_pkg::KIND_EMPTY, '0, '0, '0, '0, 1'b1));
    else begin
      tail = expected_results.pop_back();
      tail.bytes = total[13:0];
      tail.last = 1'b1;
      expect_result(tail);
    end
    n_frames++;
  endtask

  task automatic predict_scheduler(mcs_pkg::cmd_t c);
    int unsigned nu, lim, slot;
    bit all;
    nu = active_users();
    if (c.req_type == mcs_pkg::REQ_ARRIVAL) begin
      lim = cfg_m.queue_limit;
      if (lim > QDEP) lim = QDEP;
      if (c.user_id >= nu || q_cnt[c.user_id] >= lim) begin
        expect_result(mk(mcs_pkg::KIND_DROPPED, c.user_id, c.pkt_bytes,
                         c.arrival_stamp, '0, 1'b1));
        n_drops++;
        return;
      end
      slot = (q_head[c.user_id] + q_cnt[c.user_id]) % QDEP;
      pkt_mem[c.user_id*QDEP + slot] = {c.pkt_bytes, c.arrival_stamp};
      q_cnt[c.user_id]++;
      expect_result(mk(mcs_pkg::KIND_QUEUED, c.user_id, c.pkt_bytes,
                       c.arrival_stamp, '0, 1'b1));
      return;
    end
    if (c.user_id >= nu) return;
    cqi_m[c.user_id] = c.cqi_value;
    rep_seen[c.user_id] = 1'b1;
    all = 1'b1;
    for (int u = 0; u < nu; u++) if (!rep_seen[u]) all = 1'b0;
    if (!all) return;
    build_frame_results(nu);
    for (int u = 0; u < NUSR; u++) rep_seen[u] = 1'b0;
  endtask

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  int push_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        predict_scheduler(pending_cmds.pop_front());
        n_items++;
      end
      if (push && full) begin
      end else if (push_gap > 0) begin
        push_gap <= push_gap - 1;
        push <= 1'b0;
      end else if (pending_cmds.size() > 0 && !hold_push) begin
        automatic mcs_pkg::cmd_t nx = pending_cmds[0];
        push <= 1'b1;
        req_type <= nx.req_type; user_id <= nx.user_id; pkt_bytes <= nx.pkt_bytes;
        arrival_stamp <= nx.arrival_stamp; cqi_value <= nx.cqi_value;
        push_gap <= gap_len();
      end else
        push <= 1'b0;
    end
  end

  task automatic report_mismatch(string what, mcs_pkg::result_t got,
                                 mcs_pkg::result_t want);
    errors++;
    $display("mismatch %s: got %p expected %p", what, got, want);
  endtask

  // monitor
  int pop_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        automatic mcs_pkg::result_t got = mk(result_kind, served_user, served_size,
                                             served_stamp, frame_bytes, last);
        n_results++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", got, got);
        end else begin
          automatic mcs_pkg::result_t w = expected_results.pop_front();
          if (got.kind != w.kind) report_mismatch("kind", got, w);
          if (got.user != w.user) report_mismatch("user", got, w);
          if (got.size != w.size) report_mismatch("size", got, w);
          if (got.stamp != w.stamp) report_mismatch("stamp", got, w);
          if (got.bytes != w.bytes) report_mismatch("bytes", got, w);
          if (got.last != w.last) report_mismatch("last", got, w);
        end
      end
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        pop_gap <= gap_len();
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout");
      $display("status: fail");
      $finish;
    end
  end

  function automatic mcs_pkg::cmd_t arrival(int u, int s, logic [31:0] st);
    mcs_pkg::cmd_t c;
    c.req_type = mcs_pkg::REQ_ARRIVAL; c.user_id = u[1:0]; c.pkt_bytes = s[11:0];
    c.arrival_stamp = st; c.cqi_value = 4'($urandom());
    return c;
  endfunction

  function automatic mcs_pkg::cmd_t report(int u, int q);
    mcs_pkg::cmd_t c;
    c.req_type = mcs_pkg::REQ_REPORT; c.user_id = u[1:0]; c.pkt_bytes = 12'($urandom());
    c.arrival_stamp = $urandom(); c.cqi_value = q[3:0];
    return c;
  endfunction

  task automatic queue_cmd(mcs_pkg::cmd_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mcs_pkg::REG_USER_COUNT:  cfg_m.user_count = val[2:0];
      mcs_pkg::REG_QUEUE_LIMIT: cfg_m.queue_limit = val[4:0];
      default:                  cfg_m.frame_rbs = val;
    endcase
  endtask

  task automatic random_phase(int count);
    int nu, k;
    nu = active_users();
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 9) < 7) begin
        // packets then a full round of reports
        repeat ($urandom_range(1, 6)) begin
          queue_cmd(arrival($urandom_range(0, nu - 1),
            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 600),
            $urandom()));
          k++;
        end
        for (int u = nu - 1; u >= 0; u--) begin
          queue_cmd(report(u, $urandom_range(0, 15)));
          k++;
        end
      end else begin
        queue_cmd(($urandom_range(0, 1)) ? report($urandom_range(0, 3),
          $urandom_range(0, 15)) : arrival($urandom_range(0, 3), $urandom(), $urandom()));
        k++;
      end
    end
  endtask

  initial begin
    cfg_m.user_count = 3'd4; cfg_m.queue_limit = 5'd16; cfg_m.frame_rbs = 7'd25;
    for (int u = 0; u < NUSR; u++) begin
      q_head[u] = 0; q_cnt[u] = 0; cqi_m[u] = '0; rep_seen[u] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, drops at the limit, cqi zero, ties, repeated report
    queue_cmd(arrival(0, 0, 32'h0));
    queue_cmd(arrival(1, 4095, 32'hFFFF_FFFF));
    queue_cmd(arrival(2, 100, 32'hA5A5_5A5A));
    queue_cmd(arrival(3, 40, 32'h5A5A_A5A5));
    queue_cmd(report(0, 0));
    queue_cmd(report(0, 15));
    queue_cmd(report(1, 7));
    queue_cmd(report(2, 7));
    queue_cmd(report(3, 0));
    queue_cmd(report(0, 1));
    queue_cmd(report(1, 0));
    queue_cmd(report(2, 0));
    queue_cmd(report(3, 0));
    drain();

    write_cfg(mcs_pkg::REG_USER_COUNT, 7'd0);
    write_cfg(mcs_pkg::REG_QUEUE_LIMIT, 7'd2);
    write_cfg(mcs_pkg::REG_FRAME_RBS, 7'd1);
    queue_cmd(arrival(0, 3, 32'h1));
    queue_cmd(arrival(0, 5, 32'h2));
    queue_cmd(arrival(0, 9, 32'h3));
    queue_cmd(arrival(2, 9, 32'h4));
    queue_cmd(report(3, 15));
    queue_cmd(report(0, 2));
    queue_cmd(report(0, 14));
    drain();

    write_cfg(mcs_pkg::REG_QUEUE_LIMIT, 7'd0);
    queue_cmd(arrival(0, 1, 32'h5));
    drain();

    // random phases, the largest value of each register among them
    write_cfg(mcs_pkg::REG_USER_COUNT, 7'd4);
    write_cfg(mcs_pkg::REG_QUEUE_LIMIT, 7'd31);
    write_cfg(mcs_pkg::REG_FRAME_RBS, 7'd100);
    random_phase(35);
    drain();
    write_cfg(mcs_pkg::REG_USER_COUNT, 7'd7);
    write_cfg(mcs_pkg::REG_QUEUE_LIMIT, 7'd3);
    write_cfg(mcs_pkg::REG_FRAME_RBS, 7'd127);
    random_phase(25);
    drain();
    write_cfg(mcs_pkg::REG_USER_COUNT, 7'd2);
    write_cfg(mcs_pkg::REG_QUEUE_LIMIT, 7'd16);
    write_cfg(mcs_pkg::REG_FRAME_RBS, 7'd5);
    random_phase(30);
    drain();
    write_cfg(mcs_pkg::REG_USER_COUNT, 7'd1);
    write_cfg(mcs_pkg::REG_FRAME_RBS, 7'd25);
    random_phase(25);
    drain();

    $display("run: %0d items accepted, %0d results checked, %0d frames, %0d drops",
             n_items, n_results, n_frames, n_drops);
    $display("covered user counts 0 to 7, queue limits 0 to 31, frame sizes 1 to 127");
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
